// ===== hdl/gameport_axis_autocalibrate_defines.svh =====
// Assertion macros shared by the game-port calibration reader RTL.
`ifndef GAMEPORT_AXIS_AUTOCALIBRATE_DEFINES_SVH
`define GAMEPORT_AXIS_AUTOCALIBRATE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GPAC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define GPAC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/gpac_pkg.sv =====
// Shared types, constants and control structs of the game-port calibration reader.
package gpac_pkg;

    localparam int AXES         = 4;
    localparam int CNT_W        = 20;
    localparam logic [CNT_W-1:0] COUNT_MAX = '1;
    localparam int SAMPLE_LIMIT = 1048575;
    localparam int SMP_W        = $clog2(SAMPLE_LIMIT + 1);
    localparam int IDX_W        = $clog2(AXES);
    localparam int POS_W        = 16;
    localparam int Q_W          = 16;
    localparam int NUM_W        = CNT_W + Q_W;
    localparam int DIV_STEPS    = Q_W;
    localparam int STEP_W       = $clog2(DIV_STEPS);
    localparam int FULL_SCALE   = 32767;

    // opcodes
    localparam logic [1:0] OP_READ   = 2'd0;
    localparam logic [1:0] OP_CAL    = 2'd1;
    localparam logic [1:0] OP_SAMPLE = 2'd2;

    // configuration register indexes
    localparam logic CFG_PRESENT = 1'b0;
    localparam logic CFG_USE_MID = 1'b1;
    localparam int   CFG_DATA_W  = 4;

    typedef struct packed {
        logic [1:0] opcode;
        logic [3:0] axis_level;
        logic [3:0] button_raw;
    } t_in;

    typedef struct packed {
        logic signed [POS_W-1:0] axis_zero;
        logic signed [POS_W-1:0] axis_one;
        logic signed [POS_W-1:0] axis_two;
        logic signed [POS_W-1:0] axis_three;
        logic [3:0]              buttons_pressed;
    } t_out;

    typedef enum logic [1:0] {
        K_RANGE,
        K_NEG,
        K_POS
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPD,
        S_PREP,
        S_NUM,
        S_DIV,
        S_OUT
    } t_state;

    typedef struct packed {
        logic             start;
        logic             count;
        logic             set_mid;
        logic             upd;
        logic             clr_res;
        logic             prep;
        logic             load;
        logic             step;
        logic             fin;
        logic             load_out;
        logic [IDX_W-1:0] idx;
    } t_cmd;

    typedef struct packed {
        logic present;
        logic any_present;
        logic last_sample;
        logic zero;
    } t_sts;

endpackage

// ===== hdl/gpac_dpath.sv =====
// Datapath: axis counters, min/max/midpoint store, scaling setup, serial divider, output register.
module gpac_dpath import gpac_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_in                   i_in_data,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    output t_out                  o_out_data
);

    logic [AXES-1:0]  r_present;
    logic             r_use_mid;
    logic [CNT_W-1:0] r_count [AXES];
    logic [CNT_W-1:0] r_min   [AXES];
    logic [CNT_W-1:0] r_max   [AXES];
    logic [CNT_W-1:0] r_mid   [AXES];
    logic [SMP_W-1:0] r_smp;
    logic [3:0]       r_btn;

    logic [CNT_W-1:0] n_count [AXES];

    // scaling setup and divider (payload, no reset)
    logic [CNT_W-1:0]        r_a;
    logic [CNT_W-1:0]        r_den;
    t_kind                   r_kind;
    logic [CNT_W-1:0]        r_rem;
    logic [Q_W-1:0]          r_lo;
    logic [Q_W-1:0]          r_quo;
    logic signed [POS_W-1:0] r_pos [AXES];
    t_out                    r_out;

    logic [CNT_W-1:0] c, mn, mx, md, thr, span, d_lo, d_hi;
    logic [CNT_W-1:0] n_a, n_den;
    t_kind            n_kind;
    logic             zero;
    logic [NUM_W-1:0] num;
    logic [CNT_W:0]   trial, diff;
    logic             ge;
    logic [CNT_W-1:0] n_rem;
    logic [Q_W-1:0]   q_next;
    logic [POS_W-1:0] res;
    logic [AXES-1:0]  act;

    assign act = r_present;

    always_comb begin
        for (int t = 0; t < AXES; t++) begin
            if (i_in_data.axis_level[t] && (r_count[t] != COUNT_MAX)) begin
                n_count[t] = r_count[t] + 1'b1;
            end else begin
                n_count[t] = r_count[t];
            end
        end
    end

    // scaling case selection from the updated min/max of the current axis
    always_comb begin
        c    = r_count[i_cmd.idx];
        mn   = r_min[i_cmd.idx];
        mx   = r_max[i_cmd.idx];
        md   = r_mid[i_cmd.idx];
        thr  = {3'b000, mx[CNT_W-1:3]};
        span = mx - mn;
        d_lo = md - mn;
        d_hi = mx - md;
        if (!r_use_mid) begin
            n_kind = K_RANGE;
            n_den  = span;
            n_a    = c - mn;
            zero   = (span < thr) || (span == '0);
        end else if (c < md) begin
            n_kind = K_NEG;
            n_den  = d_lo;
            n_a    = md - c;
            zero   = (span < thr) || (d_lo < thr) || (d_lo == '0);
        end else begin
            n_kind = K_POS;
            n_den  = d_hi;
            n_a    = c - md;
            zero   = (span < thr) || (d_hi < thr) || (d_hi == '0);
        end
    end

    // 32767*a = (a<<15) - a, 65534*a = (a<<16) - (a<<1)
    always_comb begin
        if (r_kind == K_RANGE) begin
            num = {r_a, 16'b0} - NUM_W'({r_a, 1'b0});
        end else begin
            num = NUM_W'({r_a, 15'b0}) - NUM_W'(r_a);
        end
    end

    // restoring divide step; quotient fits Q_W bits since a <= den
    always_comb begin
        trial  = {r_rem, r_lo[Q_W-1]};
        diff   = trial - {1'b0, r_den};
        ge     = (trial >= {1'b0, r_den});
        n_rem  = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
        q_next = {r_quo[Q_W-2:0], ge};
        case (r_kind)
            K_NEG:   res = POS_W'(0) - q_next;
            K_POS:   res = q_next;
            default: res = q_next - POS_W'(FULL_SCALE);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present <= '0;
            r_use_mid <= 1'b0;
            r_smp     <= '0;
            r_btn     <= '0;
            for (int t = 0; t < AXES; t++) begin
                r_count[t] <= '0;
                r_min[t]   <= COUNT_MAX;
                r_max[t]   <= '0;
                r_mid[t]   <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_PRESENT) begin
                    r_present <= i_cfg_data[AXES-1:0];
                end else begin
                    r_use_mid <= i_cfg_data[0];
                end
            end
            if (i_cmd.start) begin
                r_btn <= ~i_in_data.button_raw;
                r_smp <= '0;
                for (int t = 0; t < AXES; t++) begin
                    r_count[t] <= '0;
                end
            end
            if (i_cmd.count) begin
                r_smp <= r_smp + 1'b1;
                for (int t = 0; t < AXES; t++) begin
                    r_count[t] <= n_count[t];
                end
            end
            if (i_cmd.set_mid) begin
                for (int t = 0; t < AXES; t++) begin
                    r_mid[t] <= n_count[t];
                end
            end
            if (i_cmd.upd) begin
                if (r_count[i_cmd.idx] > r_max[i_cmd.idx]) begin
                    r_max[i_cmd.idx] <= r_count[i_cmd.idx];
                end
                if (r_count[i_cmd.idx] < r_min[i_cmd.idx]) begin
                    r_min[i_cmd.idx] <= r_count[i_cmd.idx];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_a    <= n_a;
            r_den  <= n_den;
            r_kind <= n_kind;
        end
        if (i_cmd.load) begin
            r_rem <= num[NUM_W-1:Q_W];
            r_lo  <= num[Q_W-1:0];
        end
        if (i_cmd.step) begin
            r_rem <= n_rem;
            r_lo  <= {r_lo[Q_W-2:0], 1'b0};
            r_quo <= q_next;
        end
        if (i_cmd.clr_res || (i_cmd.prep && zero)) begin
            r_pos[i_cmd.idx] <= '0;
        end
        if (i_cmd.step && i_cmd.fin) begin
            r_pos[i_cmd.idx] <= res;
        end
        if (i_cmd.load_out) begin
            r_out.axis_zero       <= r_pos[0];
            r_out.axis_one        <= r_pos[1];
            r_out.axis_two        <= r_pos[2];
            r_out.axis_three      <= r_pos[3];
            r_out.buttons_pressed <= r_btn;
        end
    end

    // sample counter reaches the limit on this transfer when it sits at limit-1
    assign o_sts.present     = act[i_cmd.idx];
    assign o_sts.any_present = (act != '0);
    assign o_sts.last_sample = ((i_in_data.axis_level & act) == '0)
                            || (r_smp >= SMP_W'(SAMPLE_LIMIT - 1));
    assign o_sts.zero        = zero;
    assign o_out_data        = r_out;

endmodule

// ===== hdl/gpac_ctrl.sv =====
// Controller: measurement flags, per-axis scaling sequence and output valid.
`include "gameport_axis_autocalibrate_defines.svh"
module gpac_ctrl import gpac_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state            r_state, n_state;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic              r_meas, n_meas;
    logic              r_cal, n_cal;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_out_valid, n_out_valid;
    logic              in_xfer;
    logic              advance;

    // input is taken only between scaling runs
    assign o_in_ready = (r_state == S_IDLE);
    assign in_xfer    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_meas      <= 1'b0;
            r_cal       <= 1'b0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_meas      <= n_meas;
            r_cal       <= n_cal;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_meas      = r_meas;
        n_cal       = r_cal;
        n_step      = r_step;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_cmd.idx   = r_idx;
        advance     = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    if ((i_in_data.opcode == OP_READ) || (i_in_data.opcode == OP_CAL)) begin
                        o_cmd.start = 1'b1;
                        n_meas      = 1'b1;
                        n_cal       = (i_in_data.opcode == OP_CAL);
                    end else if ((i_in_data.opcode == OP_SAMPLE) && r_meas) begin
                        o_cmd.count = 1'b1;
                        if (i_sts.last_sample) begin
                            n_meas = 1'b0;
                            if (r_cal) begin
                                n_cal         = 1'b0;
                                o_cmd.set_mid = i_sts.any_present;
                            end else begin
                                n_idx   = '0;
                                n_state = S_UPD;
                            end
                        end
                    end
                end
            end
            S_UPD: begin
                if (i_sts.present) begin
                    o_cmd.upd = 1'b1;
                    n_state   = S_PREP;
                end else begin
                    o_cmd.clr_res = 1'b1;
                    advance       = 1'b1;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                if (i_sts.zero) begin
                    advance = 1'b1;
                end else begin
                    n_state = S_NUM;
                end
            end
            S_NUM: begin
                o_cmd.load = 1'b1;
                n_step     = STEP_W'(DIV_STEPS - 1);
                n_state    = S_DIV;
            end
            S_DIV: begin
                o_cmd.step = 1'b1;
                o_cmd.fin  = (r_step == '0);
                if (r_step == '0) begin
                    advance = 1'b1;
                end else begin
                    n_step = r_step - 1'b1;
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (advance) begin
            if (r_idx == IDX_W'(AXES - 1)) begin
                n_state = S_OUT;
            end else begin
                n_idx   = r_idx + 1'b1;
                n_state = S_UPD;
            end
        end
    end

    assign o_out_valid = r_out_valid;

    `GPAC_ASSERT_NOW(a_cal_implies_meas, r_cal, r_meas, "calibrate flag without measurement")
    `GPAC_ASSERT_NOW(a_busy_not_meas, r_state != S_IDLE, !r_meas, "measuring during scaling")
    `GPAC_ASSERT_NOW(a_no_overwrite, o_cmd.load_out, !r_out_valid || i_out_ready, "result overwritten")
    `GPAC_ASSERT_NEXT(a_div_holds, (r_state == S_DIV) && (r_step != '0), r_state == S_DIV, "divide cut short")

endmodule

// ===== hdl/gameport_axis_autocalibrate.sv =====
// Top level of the game-port axis timing reader with running calibration.
// Throughput: one start or port sample per cycle, none while a finished read scales or waits to load.
// Scaling steps each present axis through update, setup, numerator and 16 divide steps,
// only update and setup if its span is too small, one clear per absent axis, then loads
// the output register, later while a result still waits to be taken.
// Reset (i_rst_n low, synchronous): control and calibration registers zero, minima all ones, no result pending.
module gameport_axis_autocalibrate import gpac_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port: index 0 present mask, index 1 midpoint scaling
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input channel: starts and port samples
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in                   i_in_data,
    // output channel: one transfer per finished read measurement
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out                  o_out_data
);

    t_cmd cmd;
    t_sts sts;

    // Controller owns the measuring/calibrating flags, the axis sequence and the
    // output valid; the datapath owns counters, calibration store and divider.
    // The output register lets new starts and samples be taken while a result
    // still waits; only a second finished read stalls until the first is taken.
    gpac_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    gpac_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_data  (o_out_data)
    );

endmodule
